FILE: design/dmst_pkg.sv
package dmst_pkg;

   // Width of the measurement counts that the loop actually uses
   localparam int COUNT_WIDTH = 32;
   // Width of the count fields on the channel
   localparam int FIELD_WIDTH = 32;
   // Width for comparing a count against a 16-bit register
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [7:0]  NEUTRAL_RESET   = 8'd90;
   localparam logic [6:0]  MARGIN_RESET    = 7'd10;
   localparam logic [7:0]  MAX_POS_RESET   = 8'd180;
   localparam logic [15:0] JUMP_RESET      = 16'd50;
   localparam logic [15:0] SPEED_TOL_RESET = 16'd10;
   localparam logic [15:0] OFFSET_TOL_RESET = 16'd10;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_NEUTRAL    = 3'd0,
      REG_MARGIN     = 3'd1,
      REG_MAX_POS    = 3'd2,
      REG_JUMP       = 3'd3,
      REG_SPEED_TOL  = 3'd4,
      REG_OFFSET_TOL = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  neutral_position;
      logic [6:0]  start_margin;
      logic [7:0]  max_position;
      logic [15:0] jump_limit;
      logic [15:0] speed_tolerance;
      logic [15:0] offset_tolerance;
   } cfg_type;

   typedef struct packed {
      logic      estop_level;
      logic      arm_level;
      count_type offset_a;
      count_type offset_b;
      count_type speed_a;
      count_type speed_b;
   } item_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       motor_on;
      logic [7:0] position;
      logic       nudge_active;
      logic [7:0] nudge_position;
      logic       red_led;
      logic       green_led;
   } result_type;

endpackage

FILE: design/dmst_req_if.sv
interface dmst_req_if;
   import dmst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   estop_level;
   logic                   arm_level;
   logic [FIELD_WIDTH-1:0] offset_a;
   logic [FIELD_WIDTH-1:0] offset_b;
   logic [FIELD_WIDTH-1:0] speed_a;
   logic [FIELD_WIDTH-1:0] speed_b;

   modport source (
      output valid, estop_level, arm_level, offset_a, offset_b, speed_a, speed_b,
      input  ready
   );

   modport sink (
      input  valid, estop_level, arm_level, offset_a, offset_b, speed_a, speed_b,
      output ready
   );

endinterface

FILE: design/dmst_rsp_if.sv
interface dmst_rsp_if;

   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       motor_on;
   logic [7:0] position;
   logic       nudge_active;
   logic [7:0] nudge_position;
   logic       red_led;
   logic       green_led;

   modport source (
      output valid, mode, motor_on, position, nudge_active, nudge_position,
             red_led, green_led,
      input  ready
   );

   modport sink (
      input  valid, mode, motor_on, position, nudge_active, nudge_position,
             red_led, green_led,
      output ready
   );

endinterface

FILE: design/dmst_csr.sv
module dmst_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dmst_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dmst_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output dmst_pkg::cfg_type                    cfg
);
   import dmst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_NEUTRAL:    cfg_in.neutral_position = csr_wdata[7:0];
            REG_MARGIN:     cfg_in.start_margin     = csr_wdata[6:0];
            REG_MAX_POS:    cfg_in.max_position     = csr_wdata[7:0];
            REG_JUMP:       cfg_in.jump_limit       = csr_wdata[15:0];
            REG_SPEED_TOL:  cfg_in.speed_tolerance  = csr_wdata[15:0];
            REG_OFFSET_TOL: cfg_in.offset_tolerance = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_position <= NEUTRAL_RESET;
         cfg_ff.start_margin     <= MARGIN_RESET;
         cfg_ff.max_position     <= MAX_POS_RESET;
         cfg_ff.jump_limit       <= JUMP_RESET;
         cfg_ff.speed_tolerance  <= SPEED_TOL_RESET;
         cfg_ff.offset_tolerance <= OFFSET_TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/dmst_core.sv
module dmst_core (
   input  logic                 clock,
   input  logic                 reset,
   input  dmst_pkg::cfg_type    cfg,
   input  dmst_pkg::item_type   item,
   input  logic                 step,
   output dmst_pkg::result_type result
);
   import dmst_pkg::*;

   typedef enum logic [1:0] {
      ST_WAIT     = 2'd0,
      ST_DISARMED = 2'd1,
      ST_RUN      = 2'd2,
      ST_STOP     = 2'd3
   } mode_type;

   mode_type  mode_ff, mode_in;
   logic      last_stop_ff;
   logic [7:0] throttle_ff, throttle_in;
   count_type last_sd_ff, last_sd_in;
   count_type last_mo_ff, last_mo_in;

   logic [8:0]       start_sum;
   logic [7:0]       start_pos;
   logic             falling;
   logic             spd_a_gt;
   logic             off_a_gt;
   count_type        sd;
   count_type        mo;
   count_type        sd_jump;
   count_type        mo_jump;
   logic             sd_ok;
   logic             mo_ok;
   logic signed [9:0] thr_s;
   logic signed [9:0] start_s;
   logic signed [9:0] max_s;
   logic signed [9:0] t_step;
   logic signed [9:0] t_clamp;
   logic signed [9:0] n_step;
   logic             motor;
   logic             red;
   logic             green;
   logic             nudge;
   logic [7:0]       pos;

   // Start position, saturated to the byte range
   assign start_sum = {1'b0, cfg.neutral_position} + {2'b00, cfg.start_margin};
   assign start_pos = start_sum[8] ? 8'hFF : start_sum[7:0];
   assign falling   = last_stop_ff & ~item.estop_level;

   assign spd_a_gt = item.speed_a > item.speed_b;
   assign off_a_gt = item.offset_a > item.offset_b;
   assign sd = spd_a_gt ? (item.speed_a - item.speed_b) : (item.speed_b - item.speed_a);
   assign mo = off_a_gt ? item.offset_b : item.offset_a;
   assign sd_jump = (sd > last_sd_ff) ? (sd - last_sd_ff) : (last_sd_ff - sd);
   assign mo_jump = (mo > last_mo_ff) ? (mo - last_mo_ff) : (last_mo_ff - mo);
   assign sd_ok = CMP_WIDTH'(sd_jump) < CMP_WIDTH'(cfg.jump_limit);
   assign mo_ok = CMP_WIDTH'(mo_jump) < CMP_WIDTH'(cfg.jump_limit);

   assign thr_s   = signed'({2'b00, throttle_ff});
   assign start_s = signed'({2'b00, start_pos});
   assign max_s   = signed'({2'b00, cfg.max_position});

   // Throttle step: clamp to max first, then to start
   always_comb begin
      t_step  = spd_a_gt ? (thr_s - 10'sd1) : (thr_s + 10'sd1);
      t_clamp = (t_step > max_s) ? max_s : t_step;
      if (t_clamp < start_s) begin
         t_clamp = start_s;
      end
   end

   // Nudge towards the lagging side, one bound only
   always_comb begin
      if (off_a_gt) begin
         n_step = thr_s - 10'sd1;
         if (n_step < start_s) begin
            n_step = start_s;
         end
      end else begin
         n_step = thr_s + 10'sd1;
         if (n_step > max_s) begin
            n_step = max_s;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      throttle_in = throttle_ff;
      last_sd_in  = last_sd_ff;
      last_mo_in  = last_mo_ff;
      motor       = 1'b0;
      red         = 1'b0;
      green       = 1'b0;
      nudge       = 1'b0;
      if ((mode_ff == ST_DISARMED || mode_ff == ST_RUN) && falling) begin
         mode_in = ST_STOP;
      end else begin
         case (mode_ff)
            ST_WAIT: begin
               if (item.estop_level) begin
                  mode_in    = ST_DISARMED;
                  last_sd_in = '0;
                  last_mo_in = '0;
               end
            end
            ST_DISARMED: begin
               if (item.arm_level) begin
                  mode_in     = ST_RUN;
                  throttle_in = start_pos;
                  motor       = 1'b1;
               end
            end
            ST_RUN: begin
               if (!item.arm_level) begin
                  mode_in    = ST_DISARMED;
                  last_sd_in = '0;
                  last_mo_in = '0;
               end else begin
                  motor = 1'b1;
                  if (sd_ok) begin
                     if (CMP_WIDTH'(sd) > CMP_WIDTH'(cfg.speed_tolerance)) begin
                        red         = 1'b1;
                        throttle_in = t_clamp[7:0];
                     end else if (mo_ok) begin
                        green = 1'b1;
                        if (CMP_WIDTH'(mo) > CMP_WIDTH'(cfg.offset_tolerance)) begin
                           red   = 1'b1;
                           nudge = 1'b1;
                        end
                     end
                  end
                  // keep the latest values even when the jump is rejected
                  last_sd_in = sd;
                  last_mo_in = mo;
               end
            end
            ST_STOP: ;
            default: ;
         endcase
      end
   end

   assign pos = (mode_in == ST_RUN) ? throttle_in : cfg.neutral_position;

   always_comb begin
      result.mode           = mode_in;
      result.motor_on       = motor;
      result.position       = pos;
      result.nudge_active   = nudge;
      result.nudge_position = nudge ? n_step[7:0] : pos;
      result.red_led        = red;
      result.green_led      = green;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ST_WAIT;
         last_stop_ff <= 1'b0;
         throttle_ff  <= NEUTRAL_RESET;
         last_sd_ff   <= '0;
         last_mo_ff   <= '0;
      end else if (step) begin
         mode_ff      <= mode_in;
         last_stop_ff <= item.estop_level;
         throttle_ff  <= throttle_in;
         last_sd_ff   <= last_sd_in;
         last_mo_ff   <= last_mo_in;
      end
   end

endmodule

FILE: design/dual_motor_sync_throttle_loop_unit.sv
// Flow: a word accepted at the request channel sits in the input register and
// its result word is loaded into the result register when the output is free.
// Throughput: one word per cycle unless stalled; state update is one pass of
// compare and clamp logic between the input register and the result register.
// Reset (synchronous, active high) empties both registers, puts the loop in
// wait-for-enable with throttle at 90 and loads the register defaults.
module dual_motor_sync_throttle_loop_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   dmst_req_if.sink                             req_ch,
   dmst_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [dmst_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dmst_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import dmst_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result_ff, result_in;
   logic       result_valid_ff, result_valid_in;
   result_type core_result;
   logic       out_free;
   logic       step;
   logic       take;

   dmst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmst_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .step   (step),
      .result (core_result)
   );

   assign out_free     = !result_valid_ff || rsp_ch.ready;
   assign step         = item_valid_ff && out_free;
   assign req_ch.ready = !item_valid_ff || out_free;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      item_valid_in   = req_ch.ready ? req_ch.valid : item_valid_ff;
      result_valid_in = out_free ? item_valid_ff : result_valid_ff;
      item_in         = item_ff;
      result_in       = result_ff;
      if (take) begin
         item_in.estop_level = req_ch.estop_level;
         item_in.arm_level   = req_ch.arm_level;
         item_in.offset_a    = req_ch.offset_a[COUNT_WIDTH-1:0];
         item_in.offset_b    = req_ch.offset_b[COUNT_WIDTH-1:0];
         item_in.speed_a     = req_ch.speed_a[COUNT_WIDTH-1:0];
         item_in.speed_b     = req_ch.speed_b[COUNT_WIDTH-1:0];
      end
      if (step) begin
         result_in = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_ch.valid          = result_valid_ff;
   assign rsp_ch.mode           = result_ff.mode;
   assign rsp_ch.motor_on       = result_ff.motor_on;
   assign rsp_ch.position       = result_ff.position;
   assign rsp_ch.nudge_active   = result_ff.nudge_active;
   assign rsp_ch.nudge_position = result_ff.nudge_position;
   assign rsp_ch.red_led        = result_ff.red_led;
   assign rsp_ch.green_led      = result_ff.green_led;

endmodule

FILE: bench/dual_motor_sync_throttle_loop_unit_tb.sv
module dual_motor_sync_throttle_loop_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmst_pkg::*;

   typedef enum logic [1:0] {
      MODE_WAIT     = 2'd0,
      MODE_DISARMED = 2'd1,
      MODE_RUNNING  = 2'd2,
      MODE_STOPPED  = 2'd3
   } loop_mode_type;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 64;
   localparam int PHASE_WORDS = 180;

   class sync_loop_tracker;
      logic [7:0]    neutral;
      logic [6:0]    margin;
      logic [7:0]    max_pos;
      logic [15:0]   jump;
      logic [15:0]   speed_tol;
      logic [15:0]   offset_tol;
      loop_mode_type mode;
      logic          last_stop;
      int            throttle;
      count_type     last_sd;
      count_type     last_mo;
      result_type    due_words[$];
      int            mismatches;
      int            words_taken;

      function new();
         neutral     = NEUTRAL_RESET;
         margin      = MARGIN_RESET;
         max_pos     = MAX_POS_RESET;
         jump        = JUMP_RESET;
         speed_tol   = SPEED_TOL_RESET;
         offset_tol  = OFFSET_TOL_RESET;
         mode        = MODE_WAIT;
         last_stop   = 1'b0;
         throttle    = int'(NEUTRAL_RESET);
         last_sd     = '0;
         last_mo     = '0;
         mismatches  = 0;
         words_taken = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            REG_NEUTRAL:    neutral    = data[7:0];
            REG_MARGIN:     margin     = data[6:0];
            REG_MAX_POS:    max_pos    = data[7:0];
            REG_JUMP:       jump       = data[15:0];
            REG_SPEED_TOL:  speed_tol  = data[15:0];
            REG_OFFSET_TOL: offset_tol = data[15:0];
            default: ;
         endcase
      endfunction

      function count_type span(count_type a, count_type b);
         return (a > b) ? a - b : b - a;
      endfunction

      function int start_pos();
         int s;
         s = int'(neutral) + int'(margin);
         return (s > 255) ? 255 : s;
      endfunction

      // Upper clamp first, so start wins when it lies above the maximum
      function int clamp_running(int v);
         if (v > int'(max_pos)) v = int'(max_pos);
         if (v < start_pos()) v = start_pos();
         return v;
      endfunction

      function void take_sample(item_type s);
         result_type r;
         count_type  sd;
         count_type  mo;
         int         t;
         logic       nudge;
         r     = '0;
         nudge = 1'b0;
         if ((mode == MODE_DISARMED || mode == MODE_RUNNING) && last_stop && !s.estop_level) begin
            mode = MODE_STOPPED;
         end else begin
            case (mode)
               MODE_WAIT: begin
                  if (s.estop_level) begin
                     mode    = MODE_DISARMED;
                     last_sd = '0;
                     last_mo = '0;
                  end
               end
               MODE_DISARMED: begin
                  if (s.arm_level) begin
                     mode       = MODE_RUNNING;
                     throttle   = start_pos();
                     r.motor_on = 1'b1;
                  end
               end
               MODE_RUNNING: begin
                  if (!s.arm_level) begin
                     mode    = MODE_DISARMED;
                     last_sd = '0;
                     last_mo = '0;
                  end else begin
                     sd = span(s.speed_a, s.speed_b);
                     mo = (s.offset_a < s.offset_b) ? s.offset_a : s.offset_b;
                     r.motor_on = 1'b1;
                     // act only on changes below the jump limit
                     if (span(sd, last_sd) < count_type'(jump)) begin
                        if (sd > count_type'(speed_tol)) begin
                           t = throttle + ((s.speed_a > s.speed_b) ? -1 : 1);
                           r.red_led = 1'b1;
                           throttle  = clamp_running(t);
                        end else if (span(mo, last_mo) < count_type'(jump)) begin
                           if (mo > count_type'(offset_tol)) begin
                              r.red_led = 1'b1;
                              nudge     = 1'b1;
                           end
                           r.green_led = 1'b1;
                        end
                     end
                     last_sd = sd;
                     last_mo = mo;
                  end
               end
               default: ;
            endcase
         end
         last_stop = s.estop_level;

         r.mode           = mode;
         r.position       = (mode == MODE_RUNNING) ? throttle[7:0] : neutral;
         r.nudge_active   = nudge;
         r.nudge_position = r.position;
         if (nudge) begin
            t = throttle;
            if (s.offset_a > s.offset_b) begin
               t = t - 1;
               if (t < start_pos()) t = start_pos();
            end else begin
               t = t + 1;
               if (t > int'(max_pos)) t = int'(max_pos);
            end
            r.nudge_position = t[7:0];
         end
         due_words.push_back(r);
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void take_word(result_type got);
         result_type want;
         words_taken++;
         if (due_words.size() == 0) begin
            $display("%0t: result word with nothing expected, got %p", $time, got);
            mismatches++;
            return;
         end
         want = due_words.pop_front();
         compare("mode", 8'(want.mode), 8'(got.mode));
         compare("motor_on", 8'(want.motor_on), 8'(got.motor_on));
         compare("position", want.position, got.position);
         compare("nudge_active", 8'(want.nudge_active), 8'(got.nudge_active));
         compare("nudge_position", want.nudge_position, got.nudge_position);
         compare("red_led", 8'(want.red_led), 8'(got.red_led));
         compare("green_led", 8'(want.green_led), 8'(got.green_led));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   dmst_req_if req_if ();
   dmst_rsp_if rsp_if ();

   dual_motor_sync_throttle_loop_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sync_loop_tracker sb;
   int               words_sent;
   int               send_idle_pct;
   int               recv_stall_pct;
   bit               hold_off_request;
   count_type        walk_sd;
   count_type        walk_mo;
   item_type         seen_sample;
   result_type       seen_word;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (req_if.valid && req_if.ready) begin
            seen_sample.estop_level = req_if.estop_level;
            seen_sample.arm_level   = req_if.arm_level;
            seen_sample.offset_a    = req_if.offset_a[COUNT_WIDTH-1:0];
            seen_sample.offset_b    = req_if.offset_b[COUNT_WIDTH-1:0];
            seen_sample.speed_a     = req_if.speed_a[COUNT_WIDTH-1:0];
            seen_sample.speed_b     = req_if.speed_b[COUNT_WIDTH-1:0];
            sb.take_sample(seen_sample);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_word.mode           = rsp_if.mode;
            seen_word.motor_on       = rsp_if.motor_on;
            seen_word.position       = rsp_if.position;
            seen_word.nudge_active   = rsp_if.nudge_active;
            seen_word.nudge_position = rsp_if.nudge_position;
            seen_word.red_led        = rsp_if.red_led;
            seen_word.green_led      = rsp_if.green_led;
            sb.take_word(seen_word);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic item_type make_sample(bit estop, bit arm, count_type off_a,
                                            count_type off_b, count_type spd_a,
                                            count_type spd_b);
      item_type w;
      w.estop_level = estop;
      w.arm_level   = arm;
      w.offset_a    = off_a;
      w.offset_b    = off_b;
      w.speed_a     = spd_a;
      w.speed_b     = spd_b;
      return w;
   endfunction

   function automatic count_type walk_toward(count_type cur, count_type goal, count_type step);
      if (goal > cur) return cur + ((goal - cur > step) ? step : goal - cur);
      return cur - ((cur - goal > step) ? step : cur - goal);
   endfunction

   // Mostly well-formed drifts around the tolerances, some jumps and some noise
   function automatic item_type random_sample();
      item_type  w;
      count_type step;
      count_type base;
      count_type extra;
      int        pick;
      pick          = $urandom_range(99);
      w.estop_level = 1'b1;
      w.arm_level   = ($urandom_range(99) >= 6);
      if (pick < 12) begin
         w.offset_a = $urandom;
         w.offset_b = $urandom;
         w.speed_a  = $urandom;
         w.speed_b  = $urandom;
         return w;
      end
      step = (sb.jump > 1) ? count_type'(sb.jump) - 1 : '0;
      if (pick < 18)
         walk_sd = walk_sd + count_type'(sb.jump) + $urandom_range(3);
      else
         walk_sd = walk_toward(walk_sd, $urandom_range(2 * int'(sb.speed_tol) + 2), step);
      if (pick >= 18 && pick < 24)
         walk_mo = walk_mo + count_type'(sb.jump) + $urandom_range(3);
      else
         walk_mo = walk_toward(walk_mo, $urandom_range(2 * int'(sb.offset_tol) + 2), step);

      base = $urandom_range(32'hFFFF_FFFF - walk_sd);
      if ($urandom_range(1)) begin
         w.speed_a = base;
         w.speed_b = base + walk_sd;
      end else begin
         w.speed_a = base + walk_sd;
         w.speed_b = base;
      end
      extra = ($urandom_range(3) == 0) ? '0 : count_type'($urandom_range(200));
      if ($urandom_range(1)) begin
         w.offset_a = walk_mo;
         w.offset_b = walk_mo + extra;
      end else begin
         w.offset_a = walk_mo + extra;
         w.offset_b = walk_mo;
      end
      return w;
   endfunction

   function automatic int idle_gap();
      int g;
      g = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) g++;
      return g;
   endfunction

   task automatic send_word(input item_type w, input int idle);
      if (idle > 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.estop_level <= w.estop_level;
      req_if.arm_level   <= w.arm_level;
      req_if.offset_a    <= FIELD_WIDTH'(w.offset_a);
      req_if.offset_b    <= FIELD_WIDTH'(w.offset_b);
      req_if.speed_a     <= FIELD_WIDTH'(w.speed_a);
      req_if.speed_b     <= FIELD_WIDTH'(w.speed_b);
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   // Drop valid and hold until every result word is back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.words_taken < words_sent) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic load_settings(input int neutral, input int margin, input int max_pos,
                                input int jump, input int speed_tol, input int offset_tol);
      write_reg(REG_NEUTRAL, CSR_DATA_WIDTH'(neutral));
      write_reg(REG_MARGIN, CSR_DATA_WIDTH'(margin));
      write_reg(REG_MAX_POS, CSR_DATA_WIDTH'(max_pos));
      write_reg(REG_JUMP, CSR_DATA_WIDTH'(jump));
      write_reg(REG_SPEED_TOL, CSR_DATA_WIDTH'(speed_tol));
      write_reg(REG_OFFSET_TOL, CSR_DATA_WIDTH'(offset_tol));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(input int profile);
      case (profile)
         1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
         3:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= REG_NEUTRAL;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.estop_level <= 1'b0;
      req_if.arm_level   <= 1'b0;
      req_if.offset_a    <= '0;
      req_if.offset_b    <= '0;
      req_if.speed_a     <= '0;
      req_if.speed_b     <= '0;
      sb                 = new();
      words_sent         = 0;
      hold_off_request   = 1'b0;
      walk_sd            = '0;
      walk_mo            = '0;
      set_idling(0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the modes on reset settings
      send_word(make_sample(0, 1, '1, '1, '1, '1), 0);
      send_word(make_sample(0, 0, 0, 0, 0, 0), 0);
      send_word(make_sample(1, 0, 0, 0, 0, 0), 0);
      send_word(make_sample(1, 0, 3, 4, 5, 6), 0);
      send_word(make_sample(1, 1, 0, 0, 0, 0), 0);
      send_word(make_sample(1, 1, 5, 7, 9, 9), 0);
      send_word(make_sample(1, 1, 5, 7, 20, 0), 0);
      send_word(make_sample(1, 1, 5, 7, 0, 20), 0);
      send_word(make_sample(1, 1, 30, 40, '1, '1), 0);
      send_word(make_sample(1, 1, 40, 30, 7, 7), 0);
      send_word(make_sample(1, 1, 40, 30, 0, 100), 0);
      send_word(make_sample(1, 1, 40, 30, 0, 100), 0);
      send_word(make_sample(1, 1, 200, 250, 3, 3), 0);
      send_word(make_sample(1, 1, 300, 350, 3, 3), 0);
      send_word(make_sample(1, 1, 300, 350, 3, 3), 0);
      send_word(make_sample(1, 1, 11, 11, 8, 8), 0);
      send_word(make_sample(1, 0, '1, 0, '1, 0), 0);
      send_word(make_sample(1, 1, '1, '1, '1, 0), 0);
      send_word(make_sample(1, 1, '1, '1, '1, 0), 0);
      send_word(make_sample(1, 1, 0, '1, '1, 0), 0);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         case (p)
            0:       load_settings(90, 10, 180, 50, 10, 10);
            1:       load_settings(0, 0, 180, 65535, 0, 0);
            2:       load_settings(180, 90, 0, 0, 65535, 65535);
            3:       load_settings(60, 5, 70, 20, 3, 4);
            5:       load_settings(255, 127, 255, 65535, 65535, 65535);
            6:       load_settings(90, 10, 180, 50, 10, 10);
            default: load_settings($urandom_range(180), $urandom_range(90), $urandom_range(180),
                                   $urandom_range(300), $urandom_range(40), $urandom_range(40));
         endcase
         set_idling(p % 4);
         // fill the pipeline against a held-off receiver
         if (p == 6) hold_off_request = 1'b1;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (p == 5 && k == PHASE_WORDS / 2) wait_drained();
            send_word(random_sample(), idle_gap());
         end
      end

      // Falling stop edge while running, then the latched stop holds
      wait_drained();
      load_settings(90, 10, 180, 50, 10, 10);
      set_idling(3);
      send_word(make_sample(1, 1, 0, 0, 0, 0), 0);
      send_word(make_sample(0, 1, 0, 0, 0, 0), idle_gap());
      for (int k = 0; k < 30; k++)
         send_word(make_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                               $urandom, $urandom, $urandom), idle_gap());
      wait_drained();
      load_settings(33, 90, 0, 0, 0, 0);
      for (int k = 0; k < 10; k++)
         send_word(make_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                               $urandom, $urandom, $urandom), idle_gap());

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
